[sv/amst_pkg.sv]
package amst_pkg;

  localparam logic [2:0] OP_PUSH      = 3'd0;
  localparam logic [2:0] OP_POP       = 3'd1;
  localparam logic [2:0] OP_TRANSLATE = 3'd2;
  localparam logic [2:0] OP_ROTATE    = 3'd3;
  localparam logic [2:0] OP_SCALE     = 3'd4;
  localparam logic [2:0] OP_POINT     = 3'd5;
  localparam logic [2:0] OP_QUAD      = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BOTTOM = 2'd2;

  typedef enum logic [2:0] {
    K_PUSH,
    K_POP,
    K_TRANSLATE,
    K_ROTATE,
    K_SCALE,
    K_POINT,
    K_QUAD,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [15:0]        angle;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [1:0]         status;
    logic               last;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/amst_ram.sv]
module amst_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/amst_fifo.sv]
module amst_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_q <= ~wptr_q;
      end
      if (rd_en) begin
        rptr_q <= ~rptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[sv/amst_front.sv]
module amst_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] val_x0_i,
  input  logic signed [31:0] val_y0_i,
  input  logic signed [31:0] val_x1_i,
  input  logic signed [31:0] val_y1_i,
  input  logic [15:0]        turn_angle_i,
  input  logic               cmd_pop_i,
  output logic               cmd_valid_o,
  output amst_pkg::cmd_t     cmd_o
);

  amst_pkg::cmd_t  cmd_in;
  amst_pkg::kind_e kind;
  logic            cmd_empty;
  logic [$bits(amst_pkg::cmd_t)-1:0] cmd_bits;

  always_comb begin
    unique case (opcode_i)
      amst_pkg::OP_PUSH:      kind = amst_pkg::K_PUSH;
      amst_pkg::OP_POP:       kind = amst_pkg::K_POP;
      amst_pkg::OP_TRANSLATE: kind = amst_pkg::K_TRANSLATE;
      amst_pkg::OP_ROTATE:    kind = amst_pkg::K_ROTATE;
      amst_pkg::OP_SCALE:     kind = amst_pkg::K_SCALE;
      amst_pkg::OP_POINT:     kind = amst_pkg::K_POINT;
      amst_pkg::OP_QUAD:      kind = amst_pkg::K_QUAD;
      default:                kind = amst_pkg::K_NOP;
    endcase
  end

  always_comb begin
    cmd_in.kind  = kind;
    cmd_in.x0    = val_x0_i;
    cmd_in.y0    = val_y0_i;
    cmd_in.x1    = val_x1_i;
    cmd_in.y1    = val_y1_i;
    cmd_in.angle = turn_angle_i;
  end

  amst_fifo #(.WIDTH($bits(amst_pkg::cmd_t))) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty),
    .data_o  (cmd_bits)
  );

  assign cmd_valid_o = !cmd_empty;
  assign cmd_o       = amst_pkg::cmd_t'(cmd_bits);

endmodule

[sv/amst_back.sv]
module amst_back #(
  parameter int STACK_DEPTH     = 32,
  parameter int FRAC_BITS       = 16,
  parameter int SINE_TABLE_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  amst_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output amst_pkg::res_t res_o
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int QSIZE = 1 << QBITS;
  localparam int QAW   = QBITS + 1;
  localparam int SW    = FRAC_BITS + 1;
  localparam int ROM_W = (QSIZE + 1) * SW;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  function automatic logic [SW-1:0] quarter_sine(input int r);
    logic [127:0] p;
    logic [63:0]  th, x2, term, sum, rnd;
    int           k;
    p  = {64'd0, HALF_PI_Q62} * {64'd0, (64'(r) << (62 - QBITS))};
    th = p[125:62];
    p  = {64'd0, th} * {64'd0, th};
    x2 = p[125:62];
    term = th;
    sum  = th;
    for (k = 1; k <= 14; k++) begin
      p    = {64'd0, term} * {64'd0, x2};
      term = p[125:62] / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rnd = (sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    return rnd[SW-1:0];
  endfunction

  function automatic logic [ROM_W-1:0] build_rom();
    logic [ROM_W-1:0] v;
    int               i;
    v = '0;
    for (i = 0; i <= QSIZE; i++) begin
      v[i*SW +: SW] = quarter_sine(i);
    end
    return v;
  endfunction

  localparam logic [ROM_W-1:0] SINE_ROM = build_rom();

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_POP  = 10'b0000000010,
    S_ROT0 = 10'b0000000100,
    S_ROT1 = 10'b0000001000,
    S_ROT2 = 10'b0000010000,
    S_MUL0 = 10'b0000100000,
    S_MUL1 = 10'b0001000000,
    S_ACC  = 10'b0010000000,
    S_DONE = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_e;

  state_e             state_q;
  amst_pkg::cmd_t     cmd_q;
  logic [1:0]         pair_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [1:0]         status_q;
  logic signed [31:0] ma_q, mb_q, mc_q, md_q, me_q, mf_q;
  logic signed [31:0] cs_q, sn_q, hold_x_q, hold_y_q;
  logic [SW-1:0]      rom_q;
  logic               rneg_q;
  logic signed [63:0] prod_x_q, prod_y_q, acc_x_q, acc_y_q;

  logic                       take, ram_we, lvl_full, lvl_bottom;
  logic [LVL_W-1:0]           lvl_m1, lvl_m2;
  logic [6*32-1:0]            ram_rdata;
  logic [SINE_TABLE_BITS-1:0] idx, cos_idx, rom_idx;
  logic [QAW-1:0]             rom_addr;
  logic signed [31:0]         rom_val, rom_sv;
  logic signed [31:0]         vx, vy, k0, k1, add_x, add_y, mul_k, mul_mx, mul_my;
  logic                       neg1, is_vertex;
  logic signed [63:0]         fx, fy;
  logic signed [31:0]         sat_x, sat_y;

  assign take       = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_pop_o  = take;
  assign lvl_full   = (lvl_q == LVL_W'(STACK_DEPTH));
  assign lvl_bottom = (lvl_q == LVL_W'(1));
  assign lvl_m1     = lvl_q - LVL_W'(1);
  assign lvl_m2     = lvl_q - LVL_W'(2);
  assign ram_we     = take && (cmd_i.kind == amst_pkg::K_PUSH) && !lvl_full;

  amst_ram #(.WIDTH(6 * 32), .DEPTH(STACK_DEPTH)) u_levels (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lvl_m1[AW-1:0]),
    .wdata_i ({mf_q, me_q, md_q, mc_q, mb_q, ma_q}),
    .raddr_i (lvl_m2[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // quarter-wave table: fold the index, sign comes from the upper half
  assign idx      = cmd_q.angle[15 -: SINE_TABLE_BITS];
  assign cos_idx  = idx + SINE_TABLE_BITS'(QSIZE);
  assign rom_idx  = (state_q == S_ROT0) ? cos_idx : idx;
  assign rom_addr = rom_idx[QBITS] ? (QAW'(QSIZE) - {1'b0, rom_idx[QBITS-1:0]})
                                   : {1'b0, rom_idx[QBITS-1:0]};
  assign rom_val  = $signed({{(32 - SW){1'b0}}, rom_q});
  assign rom_sv   = rneg_q ? -rom_val : rom_val;

  always_ff @(posedge clk_i) begin
    rom_q  <= SINE_ROM[int'(rom_addr) * SW +: SW];
    rneg_q <= rom_idx[SINE_TABLE_BITS-1];
  end

  assign is_vertex = (cmd_q.kind == amst_pkg::K_TRANSLATE) ||
                     (cmd_q.kind == amst_pkg::K_POINT) || (cmd_q.kind == amst_pkg::K_QUAD);

  // quad corners: (x0,y0) (x0,y1) (x1,y1) (x1,y0)
  always_comb begin
    vx = cmd_q.x0;
    vy = cmd_q.y0;
    if (cmd_q.kind == amst_pkg::K_QUAD) begin
      if (pair_q[1]) begin
        vx = cmd_q.x1;
      end
      if (pair_q[1] ^ pair_q[0]) begin
        vy = cmd_q.y1;
      end
    end
  end

  always_comb begin
    k0    = vx;
    k1    = vy;
    neg1  = 1'b0;
    add_x = me_q;
    add_y = mf_q;
    if (cmd_q.kind == amst_pkg::K_ROTATE) begin
      k0    = pair_q[0] ? sn_q : cs_q;
      k1    = pair_q[0] ? cs_q : sn_q;
      neg1  = !pair_q[0];
      add_x = '0;
      add_y = '0;
    end else if (cmd_q.kind == amst_pkg::K_SCALE) begin
      k0    = pair_q[0] ? 32'sd0 : cmd_q.x0;
      k1    = pair_q[0] ? cmd_q.y0 : 32'sd0;
      add_x = '0;
      add_y = '0;
    end
  end

  assign mul_k  = (state_q == S_MUL0) ? k0 : k1;
  assign mul_mx = (state_q == S_MUL0) ? ma_q : mc_q;
  assign mul_my = (state_q == S_MUL0) ? mb_q : md_q;
  assign fx     = prod_x_q >>> FRAC_BITS;
  assign fy     = prod_y_q >>> FRAC_BITS;
  assign sat_x  = amst_pkg::sat32(acc_x_q);
  assign sat_y  = amst_pkg::sat32(acc_y_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_ROT1) begin
      cs_q <= rom_sv;
    end
    if (state_q == S_ROT2) begin
      sn_q <= -rom_sv;
    end
    prod_x_q <= {{32{mul_mx[31]}}, mul_mx} * {{32{mul_k[31]}}, mul_k};
    prod_y_q <= {{32{mul_my[31]}}, mul_my} * {{32{mul_k[31]}}, mul_k};
    unique case (state_q)
      S_MUL0: begin
        acc_x_q <= 64'(add_x);
        acc_y_q <= 64'(add_y);
      end
      S_MUL1: begin
        acc_x_q <= acc_x_q + fx;
        acc_y_q <= acc_y_q + fy;
      end
      S_ACC: begin
        acc_x_q <= neg1 ? acc_x_q - fx : acc_x_q + fx;
        acc_y_q <= neg1 ? acc_y_q - fy : acc_y_q + fy;
      end
      default: begin
        acc_x_q <= acc_x_q;
        acc_y_q <= acc_y_q;
      end
    endcase
    if ((state_q == S_DONE) && !is_vertex && !pair_q[0]) begin
      hold_x_q <= sat_x;
      hold_y_q <= sat_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pair_q   <= 2'd0;
      status_q <= amst_pkg::ST_OK;
      lvl_q    <= LVL_W'(1);
      ma_q     <= 32'sd1 <<< FRAC_BITS;
      mb_q     <= '0;
      mc_q     <= '0;
      md_q     <= 32'sd1 <<< FRAC_BITS;
      me_q     <= '0;
      mf_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            pair_q   <= 2'd0;
            status_q <= amst_pkg::ST_OK;
            unique case (cmd_i.kind)
              amst_pkg::K_PUSH: begin
                if (lvl_full) begin
                  status_q <= amst_pkg::ST_FULL;
                end else begin
                  lvl_q <= lvl_q + LVL_W'(1);
                end
                state_q <= S_EMIT;
              end
              amst_pkg::K_POP: begin
                if (lvl_bottom) begin
                  status_q <= amst_pkg::ST_BOTTOM;
                  state_q  <= S_EMIT;
                end else begin
                  lvl_q   <= lvl_m1;
                  state_q <= S_POP;
                end
              end
              amst_pkg::K_ROTATE: state_q <= S_ROT0;
              amst_pkg::K_NOP:    state_q <= S_EMIT;
              default:            state_q <= S_MUL0;
            endcase
          end
        end
        S_POP: begin
          ma_q    <= ram_rdata[31:0];
          mb_q    <= ram_rdata[63:32];
          mc_q    <= ram_rdata[95:64];
          md_q    <= ram_rdata[127:96];
          me_q    <= ram_rdata[159:128];
          mf_q    <= ram_rdata[191:160];
          state_q <= S_EMIT;
        end
        S_ROT0: state_q <= S_ROT1;
        S_ROT1: state_q <= S_ROT2;
        S_ROT2: state_q <= S_MUL0;
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_ACC;
        S_ACC:  state_q <= S_DONE;
        S_DONE: begin
          unique case (cmd_q.kind)
            amst_pkg::K_TRANSLATE: begin
              me_q    <= sat_x;
              mf_q    <= sat_y;
              state_q <= S_EMIT;
            end
            amst_pkg::K_POINT: begin
              if (!res_full_i) begin
                state_q <= S_IDLE;
              end
            end
            amst_pkg::K_QUAD: begin
              if (!res_full_i) begin
                pair_q  <= pair_q + 2'd1;
                state_q <= (pair_q == 2'd3) ? S_IDLE : S_MUL0;
              end
            end
            default: begin
              // rotate and scale: hold the first column pair until the second is done
              if (pair_q[0]) begin
                ma_q    <= hold_x_q;
                mb_q    <= hold_y_q;
                mc_q    <= sat_x;
                md_q    <= sat_y;
                state_q <= S_EMIT;
              end else begin
                pair_q  <= 2'd1;
                state_q <= S_MUL0;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_push_o   = 1'b0;
    res_o.vert_x = '0;
    res_o.vert_y = '0;
    res_o.status = status_q;
    res_o.last   = 1'b1;
    if ((state_q == S_DONE) && ((cmd_q.kind == amst_pkg::K_POINT) ||
                                (cmd_q.kind == amst_pkg::K_QUAD))) begin
      res_push_o   = !res_full_i;
      res_o.vert_x = sat_x;
      res_o.vert_y = sat_y;
      res_o.status = amst_pkg::ST_OK;
      res_o.last   = (cmd_q.kind == amst_pkg::K_POINT) || (pair_q == 2'd3);
    end else if (state_q == S_EMIT) begin
      res_push_o = !res_full_i;
    end
  end

endmodule

[sv/affine_matrix_stack_transform.sv]
// Stack of 2D affine matrices (six fixed-point words per level, identity at
// depth one) with vertex transform. Commands enter a two-entry queue and
// results leave through a two-entry queue, so either side can stall alone.
// The executing side uses one pair of 32x32 multipliers, one matrix column
// pair or one vertex at a time: one pass for point and translate, two for
// scale and rotate (rotate first reads the sine table), four for a quad.
// Pop first reads the RAM. The top level lives in flip-flops; lower levels
// sit in a RAM of STACK_DEPTH entries written on push and read on pop.
module affine_matrix_stack_transform #(
  parameter int STACK_DEPTH     = 32,
  parameter int FRAC_BITS       = 16,
  parameter int SINE_TABLE_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] val_x0_i,
  input  logic signed [31:0] val_y0_i,
  input  logic signed [31:0] val_x1_i,
  input  logic signed [31:0] val_y1_i,
  input  logic [15:0]        turn_angle_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  amst_pkg::cmd_t cmd;
  amst_pkg::res_t res_in, res_out;
  logic           cmd_valid, cmd_pop, res_push, res_full;
  logic [$bits(amst_pkg::res_t)-1:0] res_bits;

  amst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .val_x0_i     (val_x0_i),
    .val_y0_i     (val_y0_i),
    .val_x1_i     (val_x1_i),
    .val_y1_i     (val_y1_i),
    .turn_angle_i (turn_angle_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  amst_back #(
    .STACK_DEPTH     (STACK_DEPTH),
    .FRAC_BITS       (FRAC_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  amst_fifo #(.WIDTH($bits(amst_pkg::res_t))) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_bits)
  );

  assign res_out  = amst_pkg::res_t'(res_bits);
  assign vert_x_o = res_out.vert_x;
  assign vert_y_o = res_out.vert_y;
  assign status_o = res_out.status;
  assign last_o   = res_out.last;

endmodule

[sv/amst_check.sv]
module amst_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] vert_x_o,
  input logic [31:0] vert_y_o,
  input logic [1:0]  status_o,
  input logic        last_o
);

  logic [3:0] pend_q;
  logic       in_beat, last_beat;

  assign in_beat   = push && !full;
  assign last_beat = pop && !empty && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else if (in_beat && !last_beat) begin
      pend_q <= pend_q + 4'd1;
    end else if (last_beat && !in_beat) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  // no result without an outstanding input
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pend_q != 4'd0)
    else $error("result shown with no input outstanding");

  a_refusal_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != 2'd0) |-> (last_o && vert_x_o == 32'd0 && vert_y_o == 32'd0))
    else $error("refused command result not a single zero beat");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o != 2'd3)
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(vert_x_o) && $stable(vert_y_o) &&
                          $stable(status_o) && $stable(last_o)))
    else $error("waiting result changed");

endmodule

bind affine_matrix_stack_transform amst_check u_amst_check (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .vert_x_o (vert_x_o),
  .vert_y_o (vert_y_o),
  .status_o (status_o),
  .last_o   (last_o)
);
